FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each one checks a property on the rising
// edge of the given clock and is switched off while the active-low reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: rtl/tlb_pkg.sv
`default_nettype none

package tlb_pkg;

    // Request commands.
    localparam logic [1:0] CMD_SET_FILLER = 2'd0;
    localparam logic [1:0] CMD_INSERT     = 2'd1;
    localparam logic [1:0] CMD_LOOKUP     = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_SIL_PHONE   = 1'b0;
    localparam logic CFG_SIL_PRESENT = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_SEARCH,
        ST_FL_L,
        ST_FL_R,
        ST_FL_CAP,
        ST_DONE
    } tlb_state_t;

    // Access strobes for a single-port memory.
    typedef struct packed {
        logic rd;
        logic wr;
    } tlb_port_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/tlb_table.sv
`default_nettype none

// Triphone table: one read/write port, registered read data.
module tlb_table #(
    parameter int ADDR_W = 20,
    parameter int ENT_W  = 17
) (
    input  wire                     clk,
    input  tlb_pkg::tlb_port_ctl_t  ctl,
    input  wire  [ADDR_W-1:0]       addr,
    input  wire  [ENT_W-1:0]        wdata,
    output logic [ENT_W-1:0]        rdata
);
    import tlb_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/tlb_flags.sv
`default_nettype none

// Filler flag per base phone: one read/write port, registered read data.
module tlb_flags #(
    parameter int CI_BITS = 6
) (
    input  wire                     clk,
    input  tlb_pkg::tlb_port_ctl_t  ctl,
    input  wire  [CI_BITS-1:0]      addr,
    input  wire                     wdata,
    output logic                    rdata
);
    import tlb_pkg::*;

    localparam int DEPTH = 1 << CI_BITS;

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/tlb_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

// Sequencer: clearing pass, request decode, probe loop over the table port,
// filler-to-silence substitution and the output register.
module tlb_ctrl #(
    parameter int CI_BITS   = 6,
    parameter int POSITIONS = 4,
    parameter int PID_BITS  = 16,
    parameter int POS_W     = 2,
    parameter int ADDR_W    = 20
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [1:0]              cmd,
    input  wire  [CI_BITS-1:0]      base_phone,
    input  wire  [CI_BITS-1:0]      left_ctx,
    input  wire  [CI_BITS-1:0]      right_ctx,
    input  wire                     left_known,
    input  wire                     right_known,
    input  wire  [1:0]              word_pos,
    input  wire  [PID_BITS-1:0]     new_phone_id,
    input  wire                     filler_in,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [PID_BITS-1:0]     phone_out,
    output logic                    backed_off,
    output logic                    status,
    input  wire  [CI_BITS-1:0]      sil_phone,
    input  wire                     sil_present,
    output tlb_pkg::tlb_port_ctl_t  tbl_ctl,
    output logic [ADDR_W-1:0]       tbl_addr,
    output logic [PID_BITS:0]       tbl_wdata,
    input  wire  [PID_BITS:0]       tbl_rdata,
    output tlb_pkg::tlb_port_ctl_t  flg_ctl,
    output logic [CI_BITS-1:0]      flg_addr,
    output logic                    flg_wdata,
    input  wire                     flg_rdata
);
    import tlb_pkg::*;

    localparam int STEP_W = $clog2(POSITIONS + 2);

    tlb_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                chk_reg, chk_next;
    logic                pass_reg, pass_next;
    logic                out_valid_reg, out_valid_next;

    logic [CI_BITS-1:0]  b_reg, b_next;
    logic [CI_BITS-1:0]  l_reg, l_next;
    logic [CI_BITS-1:0]  r_reg, r_next;
    logic [1:0]          pos_reg, pos_next;
    logic [PID_BITS-1:0] newid_reg, newid_next;
    logic                fl_l_reg, fl_l_next;
    logic [PID_BITS-1:0] res_phone_reg, res_phone_next;
    logic                res_backed_reg, res_backed_next;
    logic                res_status_reg, res_status_next;
    logic [PID_BITS-1:0] out_phone_reg, out_phone_next;
    logic                out_backed_reg, out_backed_next;
    logic                out_status_reg, out_status_next;

    logic                pos_ok;
    logic [STEP_W-1:0]   step_t;
    logic [POS_W-1:0]    probe_pos;
    logic                probe_use;
    logic                steps_done;
    logic [CI_BITS-1:0]  sub_l;
    logic [CI_BITS-1:0]  sub_r;

    // Probe order: the requested position first, then every other position
    // in ascending order.
    always_comb
    begin
        pos_ok     = (8'(pos_reg) < 8'(POSITIONS));
        step_t     = step_reg - STEP_W'(1);
        steps_done = (8'(step_reg) > 8'(POSITIONS));
        if (step_reg == '0)
        begin
            probe_pos = POS_W'(pos_reg);
            probe_use = pos_ok;
        end
        else
        begin
            probe_pos = POS_W'(step_t);
            probe_use = !(pos_ok && (8'(step_t) == 8'(pos_reg)));
        end
        sub_l = fl_l_reg ? sil_phone : l_reg;
        sub_r = flg_rdata ? sil_phone : r_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        step_next       = step_reg;
        chk_next        = chk_reg;
        pass_next       = pass_reg;
        out_valid_next  = out_valid_reg;
        b_next          = b_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        pos_next        = pos_reg;
        newid_next      = newid_reg;
        fl_l_next       = fl_l_reg;
        res_phone_next  = res_phone_reg;
        res_backed_next = res_backed_reg;
        res_status_next = res_status_reg;
        out_phone_next  = out_phone_reg;
        out_backed_next = out_backed_reg;
        out_status_next = out_status_reg;
        in_ready        = 1'b0;
        tbl_ctl         = '0;
        tbl_addr        = {probe_pos, b_reg, l_reg, r_reg};
        tbl_wdata       = {1'b1, newid_reg};
        flg_ctl         = '0;
        flg_addr        = l_reg;
        flg_wdata       = filler_in;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                tbl_ctl.wr = 1'b1;
                tbl_addr   = clr_reg;
                tbl_wdata  = '0;
                flg_ctl.wr = 1'b1;
                flg_addr   = clr_reg[CI_BITS-1:0];
                flg_wdata  = 1'b0;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    b_next          = base_phone;
                    l_next          = left_ctx;
                    r_next          = right_ctx;
                    pos_next        = word_pos;
                    newid_next      = new_phone_id;
                    res_phone_next  = '0;
                    res_backed_next = 1'b0;
                    res_status_next = 1'b0;
                    step_next       = '0;
                    chk_next        = 1'b0;
                    pass_next       = 1'b0;
                    state_next      = ST_DONE;
                    case (cmd)
                        CMD_SET_FILLER:
                        begin
                            flg_ctl.wr = 1'b1;
                            flg_addr   = base_phone;
                        end
                        CMD_INSERT:
                        begin
                            state_next = ST_INS_RD;
                        end
                        CMD_LOOKUP:
                        begin
                            if (left_known && right_known)
                            begin
                                state_next = ST_SEARCH;
                            end
                            else
                            begin
                                res_phone_next  = PID_BITS'(base_phone);
                                res_backed_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_INS_RD:
            begin
                if (pos_ok)
                begin
                    tbl_ctl.rd = 1'b1;
                    tbl_addr   = {POS_W'(pos_reg), b_reg, l_reg, r_reg};
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_INS_CHK:
            begin
                tbl_addr = {POS_W'(pos_reg), b_reg, l_reg, r_reg};
                if (tbl_rdata[PID_BITS])
                begin
                    res_status_next = 1'b1;
                end
                else
                begin
                    tbl_ctl.wr = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_SEARCH:
            begin
                // A read issued last cycle is checked while the next is issued.
                if (chk_reg && tbl_rdata[PID_BITS])
                begin
                    res_phone_next = tbl_rdata[PID_BITS-1:0];
                    chk_next       = 1'b0;
                    state_next     = ST_DONE;
                end
                else if (!steps_done)
                begin
                    tbl_ctl.rd = probe_use;
                    chk_next   = probe_use;
                    step_next  = step_reg + STEP_W'(1);
                end
                else
                begin
                    chk_next = 1'b0;
                    if (!pass_reg && sil_present)
                    begin
                        state_next = ST_FL_L;
                    end
                    else
                    begin
                        res_phone_next  = PID_BITS'(b_reg);
                        res_backed_next = 1'b1;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_FL_L:
            begin
                flg_ctl.rd = 1'b1;
                flg_addr   = l_reg;
                state_next = ST_FL_R;
            end

            ST_FL_R:
            begin
                flg_ctl.rd = 1'b1;
                flg_addr   = r_reg;
                fl_l_next  = flg_rdata;
                state_next = ST_FL_CAP;
            end

            ST_FL_CAP:
            begin
                if ((sub_l != l_reg) || (sub_r != r_reg))
                begin
                    l_next     = sub_l;
                    r_next     = sub_r;
                    pass_next  = 1'b1;
                    step_next  = '0;
                    chk_next   = 1'b0;
                    state_next = ST_SEARCH;
                end
                else
                begin
                    res_phone_next  = PID_BITS'(b_reg);
                    res_backed_next = 1'b1;
                    state_next      = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_phone_next  = res_phone_reg;
                    out_backed_next = res_backed_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            step_reg      <= '0;
            chk_reg       <= 1'b0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            step_reg      <= step_next;
            chk_reg       <= chk_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg          <= b_next;
        l_reg          <= l_next;
        r_reg          <= r_next;
        pos_reg        <= pos_next;
        newid_reg      <= newid_next;
        fl_l_reg       <= fl_l_next;
        res_phone_reg  <= res_phone_next;
        res_backed_reg <= res_backed_next;
        res_status_reg <= res_status_next;
        out_phone_reg  <= out_phone_next;
        out_backed_reg <= out_backed_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign phone_out  = out_phone_reg;
    assign backed_off = out_backed_reg;
    assign status     = out_status_reg;

    `ASSERT_NEVER(a_tbl_rd_wr, clk, rst_n, tbl_ctl.rd && tbl_ctl.wr)
    `ASSERT_CLK(a_chk_after_rd, clk, rst_n, chk_reg |-> $past(tbl_ctl.rd))
    `ASSERT_CLK(a_ins_wr_after_rd, clk, rst_n, (tbl_ctl.wr && state_reg == ST_INS_CHK) |-> $past(tbl_ctl.rd))
    `ASSERT_CLK(a_search_ends, clk, rst_n, (state_reg == ST_SEARCH && steps_done) |=> state_reg != ST_SEARCH)

endmodule

`default_nettype wire

FILE: rtl/triphone_lookup_backoff_top.sv
`default_nettype none

// Context-dependent phone map. Requests set a base phone's filler flag, insert
// a (base, left, right, word position) key with a phone id, or look up the
// nearest phone. All table traffic goes through one read/write port of the
// triphone memory, driven by a small sequencer that issues one probe per cycle
// and checks the registered read data of the previous probe in the same cycle.
// After reset the block runs a clearing pass over all 2^(POS_W + 3*CI_BITS)
// table entries (1,048,576 with the default parameters) before it takes its
// first request; configuration writes are taken throughout. A filler write or
// an unused command goes straight to the result, an insert reads the entry at
// its position and writes it only if it is empty, and a lookup with an unknown
// context backs off to the base phone without a probe. Any other lookup runs
// the first probe pass. When that pass finds nothing and a silence phone is
// configured, the two filler flags are read as well; if no context changes the
// lookup backs off to the base phone, else the filler-to-silence pass runs.
// The result sits in an output register, so the next request is taken while a
// result still waits for out_ready.
module triphone_lookup_backoff_top #(
    parameter int CI_BITS   = 6,
    parameter int POSITIONS = 4,
    parameter int PID_BITS  = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire                 cfg_index,
    input  wire  [CI_BITS-1:0]  cfg_data,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [1:0]          cmd,
    input  wire  [CI_BITS-1:0]  base_phone,
    input  wire  [CI_BITS-1:0]  left_ctx,
    input  wire  [CI_BITS-1:0]  right_ctx,
    input  wire                 left_known,
    input  wire                 right_known,
    input  wire  [1:0]          word_pos,
    input  wire  [PID_BITS-1:0] new_phone_id,
    input  wire                 filler_in,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [PID_BITS-1:0] phone_out,
    output logic                backed_off,
    output logic                status
);
    import tlb_pkg::*;

    // Position bits in the table address; a single position still takes one bit.
    localparam int POS_W  = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int ADDR_W = POS_W + 3 * CI_BITS;
    localparam int ENT_W  = PID_BITS + 1;

    logic [CI_BITS-1:0] sil_phone_reg;
    logic               sil_present_reg;

    tlb_port_ctl_t      tbl_ctl;
    logic [ADDR_W-1:0]  tbl_addr;
    logic [ENT_W-1:0]   tbl_wdata;
    logic [ENT_W-1:0]   tbl_rdata;
    tlb_port_ctl_t      flg_ctl;
    logic [CI_BITS-1:0] flg_addr;
    logic               flg_wdata;
    logic               flg_rdata;

    // Configuration registers: the silence phone and whether it exists.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sil_phone_reg   <= '0;
            sil_present_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIL_PHONE:
                begin
                    sil_phone_reg <= cfg_data;
                end
                CFG_SIL_PRESENT:
                begin
                    sil_present_reg <= cfg_data[0];
                end
                default:
                begin
                    sil_present_reg <= sil_present_reg;
                end
            endcase
        end
    end

    // The sequencer owns both memory ports and the output register.
    tlb_ctrl #(
        .CI_BITS   (CI_BITS),
        .POSITIONS (POSITIONS),
        .PID_BITS  (PID_BITS),
        .POS_W     (POS_W),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .base_phone   (base_phone),
        .left_ctx     (left_ctx),
        .right_ctx    (right_ctx),
        .left_known   (left_known),
        .right_known  (right_known),
        .word_pos     (word_pos),
        .new_phone_id (new_phone_id),
        .filler_in    (filler_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .phone_out    (phone_out),
        .backed_off   (backed_off),
        .status       (status),
        .sil_phone    (sil_phone_reg),
        .sil_present  (sil_present_reg),
        .tbl_ctl      (tbl_ctl),
        .tbl_addr     (tbl_addr),
        .tbl_wdata    (tbl_wdata),
        .tbl_rdata    (tbl_rdata),
        .flg_ctl      (flg_ctl),
        .flg_addr     (flg_addr),
        .flg_wdata    (flg_wdata),
        .flg_rdata    (flg_rdata)
    );

    // Each table entry is a valid bit above the stored phone id.
    tlb_table #(
        .ADDR_W (ADDR_W),
        .ENT_W  (ENT_W)
    ) u_table (
        .clk   (clk),
        .ctl   (tbl_ctl),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    tlb_flags #(
        .CI_BITS (CI_BITS)
    ) u_flags (
        .clk   (clk),
        .ctl   (flg_ctl),
        .addr  (flg_addr),
        .wdata (flg_wdata),
        .rdata (flg_rdata)
    );

endmodule

`default_nettype wire
